>>> rtl/sm3_block_hash_unit_macros.svh
// Assertion macros shared by the SM3 block hash RTL.
`ifndef SM3_BLOCK_HASH_UNIT_MACROS_SVH
`define SM3_BLOCK_HASH_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SM3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SM3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sm3_pkg.sv
// Types, constants and helper functions of the SM3 block hash.
package sm3_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] state_t;
  typedef logic [15:0][31:0] window_t;

  localparam state_t SM3_IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  localparam word_t SM3_T0 = 32'h79CC4519;
  localparam word_t SM3_T1 = 32'h7A879D8A;
  // T1 rotated by sixteen: the constant used in round sixteen.
  localparam word_t SM3_T1_ROT16 = {SM3_T1[15:0], SM3_T1[31:16]};

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    word_t r;
    r = (x << n) | (x >> (6'd32 - {1'b0, n}));
    return r;
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

>>> rtl/sm3_msg_if.sv
// Message word channel of the SM3 block hash.
interface sm3_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic        first_block;
  logic        final_block;

  modport source (output valid, output message_word, output first_block,
                  output final_block, input ready);
  modport sink (input valid, input message_word, input first_block,
                input final_block, output ready);
endinterface

>>> rtl/sm3_dig_if.sv
// Digest word channel of the SM3 block hash.
interface sm3_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_index,
                  output digest_last, input ready);
  modport sink (input valid, input digest_word, input digest_index,
                input digest_last, output ready);
endinterface

>>> rtl/sm3_block_hash_unit.sv
// A block's sixteenth request starts the rounds; for a final block, the digest words follow.
// Per block: sixteen requests, then the rounds on one shared round unit (no words taken).
// A final block then drains eight digest words, while up to 15 next-block words load.
// Reset (async, active low): chaining value to the SM3 IV, word position and flags zero.
// Reset idles the sequencer in the load state with no digest pending.
`include "sm3_block_hash_unit_macros.svh"

module sm3_block_hash_unit (
  input  logic clk_i,
  input  logic rst_ni,
  sm3_msg_if.sink   msg_i,
  sm3_dig_if.source dig_o
);
  import sm3_pkg::*;

  // Sequencer codes.
  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_OUT   = 2'd2;

  logic [1:0] state_q, state_d;
  logic [3:0] pos_q, pos_d;        // word position within the block
  logic [1:0] flags_q, flags_d;    // bit0 first, bit1 final
  logic [5:0] rnd_q, rnd_d;        // round index
  logic [2:0] idx_q, idx_d;        // digest word index
  state_t     cv_q, cv_d;          // chaining value
  state_t     v_q, v_d;            // working registers a..h
  window_t    w_q, w_d;            // schedule window W[j..j+15]
  word_t      t_q, t_d;            // round constant rotated by j mod 32

  logic in_acc, out_acc;

  // Accept words while loading, and while the digest drains as long as the
  // block does not complete (the chaining value is still being read out).
  assign msg_i.ready = (state_q == ST_LOAD) || ((state_q == ST_OUT) && (pos_q != 4'd15));
  assign in_acc  = msg_i.valid && msg_i.ready;
  assign out_acc = dig_o.valid && dig_o.ready;

  assign dig_o.valid        = (state_q == ST_OUT);
  assign dig_o.digest_word  = cv_q[idx_q];
  assign dig_o.digest_index = idx_q;
  assign dig_o.digest_last  = (idx_q == 3'd7);

  // Shared round unit: one SM3 round plus one schedule expansion step.
  word_t a, b, c, d, e, f, g, h;
  word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic  early;
  state_t v_next;

  always_comb begin
    a = v_q[0]; b = v_q[1]; c = v_q[2]; d = v_q[3];
    e = v_q[4]; f = v_q[5]; g = v_q[6]; h = v_q[7];
    early = (rnd_q[5:4] == 2'd0);
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + t_q, 5'd7);
    ss2 = ss1 ^ a12;
    if (early) begin
      ff = a ^ b ^ c;
      gg = e ^ f ^ g;
    end else begin
      ff = (a & b) | (a & c) | (b & c);
      gg = (e & f) | (~e & g);
    end
    tt1 = ff + d + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = gg + h + ss1 + w_q[0];
    v_next = {g, rotl(f, 5'd19), e, perm0(tt2), c, rotl(b, 5'd9), a, tt1};
    w_new = perm1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15))
          ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  end

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    cv_d    = cv_q;
    v_d     = v_q;
    w_d     = w_q;
    t_d     = t_q;

    if (in_acc) begin
      // Shift the word in at the top of the window.
      w_d = {msg_i.message_word, w_q[15:1]};
      pos_d = pos_q + 4'd1;
      if (pos_q == 4'd0) begin
        flags_d = {msg_i.final_block, msg_i.first_block};
      end
      if (pos_q == 4'd15) begin
        state_d = ST_ROUND;
        rnd_d   = 6'd0;
        t_d     = SM3_T0;
        if (flags_q[0]) begin
          cv_d = SM3_IV;
          v_d  = SM3_IV;
        end else begin
          v_d  = cv_q;
        end
      end
    end

    case (state_q)
      ST_ROUND: begin
        v_d   = v_next;
        w_d   = {w_new, w_q[15:1]};
        rnd_d = rnd_q + 6'd1;
        t_d   = (rnd_q == 6'd15) ? SM3_T1_ROT16 : rotl(t_q, 5'd1);
        if (rnd_q == 6'd63) begin
          cv_d = cv_q ^ v_next;
          if (flags_q[1]) begin
            state_d = ST_OUT;
            idx_d   = 3'd0;
          end else begin
            state_d = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      pos_q   <= 4'd0;
      flags_q <= 2'd0;
      rnd_q   <= 6'd0;
      idx_q   <= 3'd0;
      cv_q    <= SM3_IV;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      cv_q    <= cv_d;
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
    t_q <= t_d;
  end

  `SM3_ASSERT_SAME(a_no_accept_in_rounds, clk_i, rst_ni,
                   state_q == ST_ROUND, !msg_i.ready,
                   "word accepted during rounds")
  `SM3_ASSERT_NEXT(a_last_digest_to_load, clk_i, rst_ni,
                   out_acc && (idx_q == 3'd7), state_q == ST_LOAD,
                   "sequencer did not return to load after last digest word")
  `SM3_ASSERT_NEXT(a_nonfinal_to_load, clk_i, rst_ni,
                   (state_q == ST_ROUND) && (rnd_q == 6'd63) && !flags_q[1],
                   (state_q == ST_LOAD) && !dig_o.valid,
                   "non-final block produced a digest")
  `SM3_ASSERT_NEXT(a_cv_stable_in_out, clk_i, rst_ni,
                   state_q == ST_OUT, $stable(cv_q),
                   "chaining value changed while digest drains")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the SM3 block hash unit: directed blocks, then random blocks.
module tb_top;
  import sm3_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD      = 500;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned NUM_DIRECTED   = 32;

  // One row of the directed table: a message request plus a mark on the row
  // whose digest is typed in below instead of being predicted.
  typedef struct packed {
    word_t word;
    logic  first_blk;
    logic  final_blk;
    logic  typed;
  } stim_row_t;

  // One digest word as it leaves the block.
  typedef struct {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_beat_t;

  // Directed part. First block: all ones, flagged first but not final, with
  // both flags raised on every later word; those must be ignored, so no digest.
  // Second block: the padded three-byte message "abc" from the SM3 standard,
  // flagged first and final, so the IV is reloaded and the standard digest
  // must appear.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    '{32'h6162_6380, 1'b1, 1'b1, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0}, '{32'h0000_0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 1'b0}, '{32'h0000_0018, 1'b0, 1'b0, 1'b1}
  };

  // Standard digest of "abc", most significant word first.
  localparam word_t ABC_DIGEST [8] = '{
    32'h66C7_F0F4, 32'h62EE_EDD9, 32'hD1F2_D46B, 32'hDC10_E4E2,
    32'h4167_C487, 32'h5CF2_F7A2, 32'h297D_A02B, 32'h8F4B_A8E0
  };

  // Idle settings per random phase: none, sender only, receiver only, both.
  localparam int unsigned GAP_PCT   [4] = '{0, 70, 0, 24};
  localparam int unsigned STALL_PCT [4] = '{0, 0, 70, 24};
  localparam int unsigned PHASE_BLOCKS [4] = '{7, 6, 6, 6};

  logic clk = 1'b0;
  logic rst_n;

  sm3_msg_if msg ();
  sm3_dig_if dig ();

  sm3_block_hash_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .msg_i  (msg),
    .dig_o  (dig)
  );

  always #5 clk = ~clk;

  // Idle knobs, written by the stimulus process only.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  // Long receiver hold-off: the stimulus bumps the request count, the drain
  // process notices the change and counts the stretch itself.
  int unsigned hold_asked = 0;

  // Predictor state: chaining value, block buffer, position and latched flags.
  state_t      hash_cv;
  window_t     blk_buf;
  int unsigned word_pos;
  logic        blk_first;
  logic        blk_final;
  logic        typed_digest_pending;
  digest_beat_t pending_digest_q [$];

  int unsigned words_taken;
  int unsigned blocks_hashed;
  int unsigned digests_checked;
  int unsigned mismatch_count;

  // ---------------------------------------------------------------------------
  // Predictor: SM3 compression of one block into a chaining value.
  // ---------------------------------------------------------------------------
  function automatic word_t rot_left(word_t x, int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic word_t spread0(word_t x);
    return x ^ rot_left(x, 9) ^ rot_left(x, 17);
  endfunction

  function automatic word_t spread1(word_t x);
    return x ^ rot_left(x, 15) ^ rot_left(x, 23);
  endfunction

  function automatic state_t compress_block(state_t cv, window_t blk);
    word_t  w [68];
    word_t  a, b, c, d, e, f, g, h;
    word_t  tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    state_t nxt;
    int     j;
    // Expand the schedule.
    for (j = 0; j < 16; j++) w[j] = blk[j];
    for (j = 16; j < 68; j++)
      w[j] = spread1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15))
           ^ rot_left(w[j-13], 7) ^ w[j-6];
    a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
    e = cv[4]; f = cv[5]; g = cv[6]; h = cv[7];
    // Run the 64 rounds; the constant rotates by the round number mod 32.
    for (j = 0; j < 64; j++) begin
      tj  = (j < 16) ? SM3_T0 : SM3_T1;
      a12 = rot_left(a, 12);
      ss1 = rot_left(a12 + e + rot_left(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rot_left(b, 9); b = a; a = tt1;
      h = g; g = rot_left(f, 19); f = e; e = spread0(tt2);
    end
    nxt = cv;
    nxt[0] ^= a; nxt[1] ^= b; nxt[2] ^= c; nxt[3] ^= d;
    nxt[4] ^= e; nxt[5] ^= f; nxt[6] ^= g; nxt[7] ^= h;
    return nxt;
  endfunction

  // Take one accepted request into the predictor; queue the eight digest
  // words when it closes a block flagged final.
  task automatic absorb_word(word_t w, logic fst, logic fin);
    int k;
    // Latch the flags only from the first word of a block.
    if (word_pos == 0) begin
      blk_first = fst;
      blk_final = fin;
    end
    blk_buf[word_pos] = w;
    if (word_pos != 15) begin
      word_pos++;
    end else begin
      word_pos = 0;
      blocks_hashed++;
      if (blk_first) hash_cv = SM3_IV;
      hash_cv = compress_block(hash_cv, blk_buf);
      if (blk_final) begin
        for (k = 0; k < 8; k++)
          pending_digest_q.push_back('{typed_digest_pending ? ABC_DIGEST[k] : hash_cv[k],
                                       k[2:0], k == 7});
        typed_digest_pending = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Compare one accepted digest word with the oldest expectation.
  task automatic check_digest();
    digest_beat_t want;
    if (pending_digest_q.size() == 0) begin
      report_mismatch($sformatf("digest word %h with nothing expected", dig.digest_word));
      return;
    end
    want = pending_digest_q.pop_front();
    digests_checked++;
    if (dig.digest_word !== want.word)
      report_mismatch($sformatf("digest_word %h, want %h", dig.digest_word, want.word));
    if (dig.digest_index !== want.idx)
      report_mismatch($sformatf("digest_index %0d, want %0d", dig.digest_index, want.idx));
    if (dig.digest_last !== want.last)
      report_mismatch($sformatf("digest_last %b, want %b", dig.digest_last, want.last));
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: sample both channels at the rising edge, before the block's
  // registers update, so every handshake is seen exactly as the block sees it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && msg.valid && msg.ready) begin
      words_taken++;
      absorb_word(msg.message_word, msg.first_block, msg.final_block);
    end
    if (rst_n && dig.valid && dig.ready) check_digest();
  end

  // ---------------------------------------------------------------------------
  // Digest drain: random stalls per phase, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : digest_drain
    int unsigned hold_left;
    int unsigned hold_served;
    hold_left   = 0;
    hold_served = 0;
    dig.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        dig.ready <= 1'b0;
      end else begin
        dig.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (msg.valid && msg.ready) || (dig.valid && dig.ready)) quiet = 0;
      else quiet++;
    end
    $display("[%0t] watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one request, called at a rising edge. Insert random gaps first, then
  // hold the request until it is accepted. Leave valid high on return: the
  // next call, in the same time step, either drops it or replaces the payload.
  task automatic offer_word(word_t w, logic fst, logic fin);
    while ($urandom_range(99) < gap_pct) begin
      msg.valid <= 1'b0;
      @(posedge clk);
    end
    msg.valid        <= 1'b1;
    msg.message_word <= w;
    msg.first_block  <= fst;
    msg.final_block  <= fin;
    do @(posedge clk); while (!msg.ready);
  endtask

  // Send one sixteen-word block with random content. Zeros and all-ones words
  // come often enough to hit the extremes; flags on later words are noise.
  task automatic send_block(logic fst, logic fin);
    int    p;
    word_t w;
    for (p = 0; p < 16; p++) begin
      case ($urandom_range(7))
        0:       w = '0;
        1:       w = '1;
        default: w = $urandom();
      endcase
      if (p == 0) offer_word(w, fst, fin);
      else offer_word(w, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    int   r, ph, b;
    logic fst, fin;

    hash_cv              = SM3_IV;
    blk_buf              = '0;
    word_pos             = 0;
    blk_first            = 1'b0;
    blk_final            = 1'b0;
    typed_digest_pending = 1'b0;
    words_taken          = 0;
    blocks_hashed        = 0;
    digests_checked      = 0;
    mismatch_count       = 0;

    rst_n            <= 1'b0;
    msg.valid        <= 1'b0;
    msg.message_word <= '0;
    msg.first_block  <= 1'b0;
    msg.final_block  <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with no idling.
    for (r = 0; r < NUM_DIRECTED; r++) begin
      if (DIRECTED_ROWS[r].typed) typed_digest_pending = 1'b1;
      offer_word(DIRECTED_ROWS[r].word, DIRECTED_ROWS[r].first_blk,
                 DIRECTED_ROWS[r].final_blk);
    end

    // Random blocks, one idle setting per phase.
    for (ph = 0; ph < 4; ph++) begin
      gap_pct   = GAP_PCT[ph];
      stall_pct = STALL_PCT[ph];
      // Hold the receiver off while final blocks keep coming, so the block
      // fills up and stalls its input.
      if (ph == 0) hold_asked++;
      // Drop valid and pause until every queued digest word has come out.
      // Step one edge first so the monitor has taken the last request.
      if (ph == 2) begin
        msg.valid <= 1'b0;
        @(posedge clk);
        wait (pending_digest_q.size() == 0);
        @(posedge clk);
      end
      for (b = 0; b < PHASE_BLOCKS[ph]; b++) begin
        fin = (ph == 0 && b < 3) ? 1'b1 : 1'($urandom_range(1));
        fst = ($urandom_range(2) == 0);
        send_block(fst, fin);
      end
    end

    // Drain: wait for every expected word, then watch for strays.
    msg.valid <= 1'b0;
    @(posedge clk);
    wait (pending_digest_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_digest_q.size() != 0)
      report_mismatch($sformatf("%0d digest words never came out", pending_digest_q.size()));

    $display("Covered %0d message words in %0d blocks, %0d digest words compared,",
             words_taken, blocks_hashed, digests_checked);
    $display("across four idle phases and one long receiver hold; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
